/* rtl/ptpr_pkg.sv */
// ============================================================================
// ptpr_pkg - shared definitions for the perspective tilt pixel remap core
// Command codes, register indexes, field widths and register reset values.
// ============================================================================
package ptpr_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int POS_W   = 6;
    localparam int PIX_W   = 32;
    localparam int SIZE_W  = 7;
    localparam int GAIN_W  = 16;
    localparam int SHEAR_W = 22;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 22;
    localparam int FRAC_W  = 14;

    typedef logic [IDX_W-1:0] t_cfg_idx;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_FETCH = 1'b1;

    localparam t_cfg_idx REG_FRAME_WIDTH     = 3'd0;
    localparam t_cfg_idx REG_FRAME_HEIGHT    = 3'd1;
    localparam t_cfg_idx REG_HORIZONTAL_GAIN = 3'd2;
    localparam t_cfg_idx REG_SHEAR_GAIN      = 3'd3;
    localparam t_cfg_idx REG_VERTICAL_GAIN   = 3'd4;

    localparam logic [SIZE_W-1:0]         RST_FRAME_WIDTH     = 7'd64;
    localparam logic [SIZE_W-1:0]         RST_FRAME_HEIGHT    = 7'd64;
    localparam logic signed [GAIN_W-1:0]  RST_HORIZONTAL_GAIN = 16'sd16384;
    localparam logic signed [SHEAR_W-1:0] RST_SHEAR_GAIN      = 22'sd0;
    localparam logic signed [GAIN_W-1:0]  RST_VERTICAL_GAIN   = 16'sd16384;

endpackage

/* rtl/perspective_tilt_pixel_remap_core.sv */
// ============================================================================
// perspective_tilt_pixel_remap_core - frame store with affine pixel lookup
// Loads write RGBA pixels into an on-chip frame store; fetches map an output
// pixel through horizontal, shear and vertical gains, clamp the source
// coordinate into the active frame and return the stored pixel.
// ============================================================================
// A fetch strobes o_valid via r_s1_vld, r_s2_vld, r_s3_vld and r_out_vld.
// Throughput: one transaction per cycle, set by the single store port; busy
// stays low and the receiver cannot stall.
// Reset: synchronous active low; clears the pipeline and restores register
// defaults. Store contents are undefined until loaded.
module perspective_tilt_pixel_remap_core
    import ptpr_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cmd,
    input  logic [POS_W-1:0]    i_pos_x,
    input  logic [POS_W-1:0]    i_pos_y,
    input  logic [PIX_W-1:0]    i_pixel_in,
    output logic                o_valid,
    output logic [PIX_W-1:0]    o_pixel_out,
    output logic [POS_W-1:0]    o_source_x,
    output logic [POS_W-1:0]    o_source_y,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [IDX_W-1:0]    i_cfg_index,
    input  logic [DATA_W-1:0]   i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [SIZE_W-1:0] W_LIM =
        (MAX_WIDTH > 127) ? 7'd127 : SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] H_LIM =
        (MAX_HEIGHT > 127) ? 7'd127 : SIZE_W'(MAX_HEIGHT);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_WIDTH);

    // configuration
    logic [SIZE_W-1:0]         r_cfg_w, r_cfg_h;
    logic signed [GAIN_W-1:0]  r_hgain, r_vgain;
    logic signed [SHEAR_W-1:0] r_sgain;
    logic [SIZE_W-1:0]         eff_w, eff_h;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RST_FRAME_WIDTH;
            r_cfg_h <= RST_FRAME_HEIGHT;
            r_hgain <= RST_HORIZONTAL_GAIN;
            r_sgain <= RST_SHEAR_GAIN;
            r_vgain <= RST_VERTICAL_GAIN;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:     r_cfg_w <= i_cfg_data[SIZE_W-1:0];
                REG_FRAME_HEIGHT:    r_cfg_h <= i_cfg_data[SIZE_W-1:0];
                REG_HORIZONTAL_GAIN: r_hgain <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_SHEAR_GAIN:      r_sgain <= $signed(i_cfg_data[SHEAR_W-1:0]);
                REG_VERTICAL_GAIN:   r_vgain <= $signed(i_cfg_data[GAIN_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_w = (r_cfg_w == '0) ? 7'd1 : ((r_cfg_w > W_LIM) ? W_LIM : r_cfg_w);
        eff_h = (r_cfg_h == '0) ? 7'd1 : ((r_cfg_h > H_LIM) ? H_LIM : r_cfg_h);
    end

    // stage 1: centered offsets
    logic                r_s1_vld, r_s1_cmd;
    logic [POS_W-1:0]    r_s1_x, r_s1_y;
    logic [PIX_W-1:0]    r_s1_pix;
    logic signed [7:0]   r_s1_ox, r_s1_oy;
    logic                accept;

    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
        r_s1_cmd <= i_cmd;
        r_s1_x   <= i_pos_x;
        r_s1_y   <= i_pos_y;
        r_s1_pix <= i_pixel_in;
        r_s1_ox  <= $signed({1'b0, i_pos_x, 1'b0}) - $signed({1'b0, eff_w});
        r_s1_oy  <= $signed({1'b0, i_pos_y, 1'b0}) - $signed({1'b0, eff_h});
    end

    // stage 2: gain products
    logic                r_s2_vld, r_s2_cmd;
    logic [POS_W-1:0]    r_s2_x, r_s2_y;
    logic [PIX_W-1:0]    r_s2_pix;
    logic signed [23:0]  r_s2_px, r_s2_pv;
    logic signed [29:0]  r_s2_ps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_cmd <= r_s1_cmd;
        r_s2_x   <= r_s1_x;
        r_s2_y   <= r_s1_y;
        r_s2_pix <= r_s1_pix;
        r_s2_px  <= r_s1_ox * r_hgain;
        r_s2_ps  <= r_s1_oy * r_sgain;
        r_s2_pv  <= r_s1_oy * r_vgain;
    end

    // stage 3: scaled source coordinates, 2*s*2^14
    logic                r_s3_vld, r_s3_cmd;
    logic [POS_W-1:0]    r_s3_x, r_s3_y;
    logic [PIX_W-1:0]    r_s3_pix;
    logic signed [31:0]  r_s3_sx;
    logic signed [25:0]  r_s3_sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_cmd <= r_s2_cmd;
        r_s3_x   <= r_s2_x;
        r_s3_y   <= r_s2_y;
        r_s3_pix <= r_s2_pix;
        r_s3_sx  <= $signed({11'b0, eff_w, 14'b0}) + 32'(r_s2_px) - 32'(r_s2_ps);
        r_s3_sy  <= $signed({5'b0, eff_h, 14'b0}) + 26'(r_s2_pv);
    end

    // stage 4: floor, clamp, store access
    logic [15:0]        qx;
    logic [9:0]         qy;
    logic [SIZE_W-1:0]  src_x, src_y, col, row;
    logic [AW-1:0]      addr;
    logic               in_store, wr_en;

    always_comb begin
        qx = r_s3_sx[30:15];
        qy = r_s3_sy[24:15];
        if (r_s3_sx[31]) begin
            src_x = '0;
        end else if (qx > 16'(eff_w - 7'd1)) begin
            src_x = eff_w - 7'd1;
        end else begin
            src_x = qx[SIZE_W-1:0];
        end
        if (r_s3_sy[25]) begin
            src_y = '0;
        end else if (qy > 10'(eff_h - 7'd1)) begin
            src_y = eff_h - 7'd1;
        end else begin
            src_y = qy[SIZE_W-1:0];
        end
        in_store = (32'(r_s3_x) < MAX_WIDTH) && (32'(r_s3_y) < MAX_HEIGHT);
        wr_en    = r_s3_vld && (r_s3_cmd == CMD_LOAD) && in_store;
        col      = (r_s3_cmd == CMD_LOAD) ? {1'b0, r_s3_x} : src_x;
        row      = (r_s3_cmd == CMD_LOAD) ? {1'b0, r_s3_y} : src_y;
        addr     = AW'(row) * ROW_STRIDE + AW'(col);
    end

    logic [PIX_W-1:0] frame_mem [DEPTH];
    logic [PIX_W-1:0] r_rdata;
    logic             r_out_vld;
    logic [POS_W-1:0] r_out_sx, r_out_sy;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            frame_mem[addr] <= r_s3_pix;
        end
        r_rdata <= frame_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_s3_vld && (r_s3_cmd == CMD_FETCH);
        end
        r_out_sx <= src_x[POS_W-1:0];
        r_out_sy <= src_y[POS_W-1:0];
    end

    assign o_valid     = r_out_vld;
    assign o_pixel_out = r_rdata;
    assign o_source_x  = r_out_sx;
    assign o_source_y  = r_out_sy;

endmodule

/* rtl/ptpr_checker.sv */
// ============================================================================
// ptpr_checker - port-level checks for the pixel remap core
// Fetch-to-result timing, silent loads, result provenance, config acceptance and reset flush.
// ============================================================================
module ptpr_checker
    import ptpr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                i_cmd,
    input  logic                o_valid,
    input  logic                i_cfg_valid,
    input  logic                o_cfg_ready
);

    logic fetch_acc, load_acc;

    assign fetch_acc = start && !busy && (i_cmd == CMD_FETCH);
    assign load_acc  = start && !busy && (i_cmd == CMD_LOAD);

    a_fetch_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fetch_acc |-> ##4 o_valid)
        else $error("fetch transaction gave no result");

    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |-> ##4 !o_valid)
        else $error("load transaction produced a result");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(fetch_acc, 4))
        else $error("result without a matching fetch transaction");

    a_cfg_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration transaction not accepted");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind perspective_tilt_pixel_remap_core ptpr_checker u_ptpr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_cmd       (i_cmd),
    .o_valid     (o_valid),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready)
);

/* tb/sv/tb_perspective_tilt_pixel_remap_core.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_perspective_tilt_pixel_remap_core - self-checking bench for the remap core
// Loads RGBA pixels into the frame store and fetches remapped pixels through
// a range of frame sizes and gain settings. An in-bench predictor mirrors the
// store and register file and tracks every fetch; a monitor compares each
// strobed result against the oldest outstanding prediction.
// ============================================================================
module tb_perspective_tilt_pixel_remap_core;
    import ptpr_pkg::*;

    localparam int MAX_W        = DEF_MAX_WIDTH;
    localparam int MAX_H        = DEF_MAX_HEIGHT;
    localparam int SETTLE_TICKS = 8;
    localparam int CYCLE_LIMIT  = 500000;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] src_x;
        logic [POS_W-1:0] src_y;
    } t_remap_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                start       = 1'b0;
    logic                busy;
    logic                i_cmd       = CMD_LOAD;
    logic [POS_W-1:0]    i_pos_x     = '0;
    logic [POS_W-1:0]    i_pos_y     = '0;
    logic [PIX_W-1:0]    i_pixel_in  = '0;
    logic                o_valid;
    logic [PIX_W-1:0]    o_pixel_out;
    logic [POS_W-1:0]    o_source_x;
    logic [POS_W-1:0]    o_source_y;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [IDX_W-1:0]    i_cfg_index = REG_FRAME_WIDTH;
    logic [DATA_W-1:0]   i_cfg_data  = '0;

    // predictor state
    logic [PIX_W-1:0]         frame_image [MAX_W*MAX_H];
    bit                       loaded_map  [MAX_W*MAX_H];
    logic [SIZE_W-1:0]        model_width = RST_FRAME_WIDTH;
    logic [SIZE_W-1:0]        model_height = RST_FRAME_HEIGHT;
    logic signed [GAIN_W-1:0] model_hgain = RST_HORIZONTAL_GAIN;
    logic signed [SHEAR_W-1:0] model_shear = RST_SHEAR_GAIN;
    logic signed [GAIN_W-1:0] model_vgain = RST_VERTICAL_GAIN;

    t_remap_result pending_remaps[$];
    int            mismatch_count = 0;
    int            cycle_count = 0;
    bit            gaps_enabled = 1'b1;

    perspective_tilt_pixel_remap_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_pixel_in  (i_pixel_in),
        .o_valid     (o_valid),
        .o_pixel_out (o_pixel_out),
        .o_source_x  (o_source_x),
        .o_source_y  (o_source_y),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("perspective_tilt_pixel_remap_core: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_remap_result exp_r;
        if (i_rst_n && o_valid) begin
            if (pending_remaps.size() == 0) begin
                $error("unexpected result: pixel_out %h source %0d,%0d",
                       o_pixel_out, o_source_x, o_source_y);
                mismatch_count++;
            end else begin
                exp_r = pending_remaps.pop_front();
                if (o_pixel_out !== exp_r.pixel) begin
                    $error("pixel_out: expected %h, actual %h", exp_r.pixel, o_pixel_out);
                    mismatch_count++;
                end
                if (o_source_x !== exp_r.src_x) begin
                    $error("source_x: expected %0d, actual %0d", exp_r.src_x, o_source_x);
                    mismatch_count++;
                end
                if (o_source_y !== exp_r.src_y) begin
                    $error("source_y: expected %0d, actual %0d", exp_r.src_y, o_source_y);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int effective_size(input logic [SIZE_W-1:0] size_reg, input int max_val);
        int s;
        s = size_reg;
        if (s < 1) s = 1;
        if (s > max_val) s = max_val;
        return s;
    endfunction

    function automatic int floor_into_frame(input longint scaled, input int size);
        longint c;
        if (scaled < 0) return 0;
        c = scaled >>> 15;
        if (c > size - 1) c = size - 1;
        return int'(c);
    endfunction

    function automatic void predict_source(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                           output int sx, output int sy);
        longint w, h, ox, oy, hg, sg, vg;
        w  = effective_size(model_width, MAX_W);
        h  = effective_size(model_height, MAX_H);
        hg = model_hgain;
        sg = model_shear;
        vg = model_vgain;
        ox = 2 * longint'(x) - w;
        oy = 2 * longint'(y) - h;
        sx = floor_into_frame(w * 16384 + ox * hg - oy * sg, int'(w));
        sy = floor_into_frame(h * 16384 + oy * vg, int'(h));
    endfunction

    // random fill above the low bits that the register keeps
    function automatic logic [DATA_W-1:0] with_noise(input logic [DATA_W-1:0] v, input int keep);
        logic [DATA_W-1:0] mask;
        mask = (22'd1 << keep) - 22'd1;
        return (v & mask) | (DATA_W'($urandom) & ~mask);
    endfunction

    task automatic send_item(input logic cmd, input logic [POS_W-1:0] x,
                             input logic [POS_W-1:0] y, input logic [PIX_W-1:0] pix);
        int sx, sy;
        t_remap_result r;
        if (gaps_enabled && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= cmd;
        i_pos_x    <= x;
        i_pos_y    <= y;
        i_pixel_in <= pix;
        do @(posedge i_clk); while (busy);
        if (cmd == CMD_LOAD) begin
            frame_image[y * MAX_W + x] = pix;
            loaded_map[y * MAX_W + x]  = 1'b1;
        end else begin
            predict_source(x, y, sx, sy);
            r.pixel = frame_image[sy * MAX_W + sx];
            r.src_x = POS_W'(sx);
            r.src_y = POS_W'(sy);
            pending_remaps.push_back(r);
        end
    endtask

    // load the source entry first when it was never written
    task automatic fetch_remapped(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        int sx, sy;
        predict_source(x, y, sx, sy);
        if (!loaded_map[sy * MAX_W + sx])
            send_item(CMD_LOAD, POS_W'(sx), POS_W'(sy), $urandom());
        send_item(CMD_FETCH, x, y, $urandom());
    endtask

    task automatic wait_results_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_remaps.size() != 0);
    endtask

    task automatic settle_block();
        wait_results_drained();
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_FRAME_WIDTH:     model_width  = data[SIZE_W-1:0];
            REG_FRAME_HEIGHT:    model_height = data[SIZE_W-1:0];
            REG_HORIZONTAL_GAIN: model_hgain  = data[GAIN_W-1:0];
            REG_SHEAR_GAIN:      model_shear  = data[SHEAR_W-1:0];
            REG_VERTICAL_GAIN:   model_vgain  = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_frame(input logic [DATA_W-1:0] wd, input logic [DATA_W-1:0] hd,
                                 input logic [DATA_W-1:0] hgd, input logic [DATA_W-1:0] sgd,
                                 input logic [DATA_W-1:0] vgd);
        settle_block();
        write_reg(REG_FRAME_WIDTH, with_noise(wd, SIZE_W));
        write_reg(REG_FRAME_HEIGHT, with_noise(hd, SIZE_W));
        write_reg(REG_HORIZONTAL_GAIN, with_noise(hgd, GAIN_W));
        write_reg(REG_SHEAR_GAIN, sgd);
        write_reg(REG_VERTICAL_GAIN, with_noise(vgd, GAIN_W));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] random_size();
        case ($urandom_range(0, 9))
            0:       return 22'd0;
            1:       return DATA_W'($urandom_range(65, 127));
            2, 3:    return DATA_W'($urandom_range(1, 64));
            default: return DATA_W'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_gain();
        case ($urandom_range(0, 7))
            0:       return 22'h008000;
            1:       return 22'h007FFF;
            default: return DATA_W'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] random_shear();
        case ($urandom_range(0, 7))
            0:       return 22'h200000;
            1:       return 22'h1FFFFF;
            2:       return 22'd0;
            3, 4:    return DATA_W'($urandom_range(0, 32768) - 16384);
            default: return DATA_W'($urandom_range(0, 2097152) - 1048576);
        endcase
    endfunction

    task automatic run_random_phase(input int n_items);
        int k;
        logic [POS_W-1:0] x, y;
        for (k = 0; k < n_items; k++) begin
            x = POS_W'($urandom);
            y = POS_W'($urandom);
            if ($urandom_range(0, 9) < 3) begin
                send_item(CMD_LOAD, x, y, $urandom());
            end else begin
                if ($urandom_range(0, 1)) begin
                    x = POS_W'($urandom_range(0, effective_size(model_width, MAX_W) - 1));
                    y = POS_W'($urandom_range(0, effective_size(model_height, MAX_H) - 1));
                end
                fetch_remapped(x, y);
            end
            if (k == n_items / 2 || $urandom_range(0, 199) == 0)
                wait_results_drained();
        end
    endtask

    task automatic test_identity_corners();
        send_item(CMD_LOAD, 6'd0, 6'd0, 32'h0000_0000);
        send_item(CMD_LOAD, 6'd63, 6'd0, 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 6'd0, 6'd63, 32'hA5A5_5A5A);
        send_item(CMD_LOAD, 6'd63, 6'd63, 32'h1234_5678);
        fetch_remapped(6'd0, 6'd0);
        fetch_remapped(6'd63, 6'd0);
        fetch_remapped(6'd0, 6'd63);
        fetch_remapped(6'd63, 6'd63);
        // read right behind a write to the same entry
        send_item(CMD_LOAD, 6'd17, 6'd42, 32'hDEAD_BEEF);
        fetch_remapped(6'd17, 6'd42);
        send_item(CMD_LOAD, 6'd17, 6'd42, 32'h5A5A_A5A5);
        fetch_remapped(6'd17, 6'd42);
    endtask

    task automatic test_frame_size_limits();
        // zero size behaves as one pixel
        program_frame(22'd0, 22'd0, 22'd16384, 22'd0, 22'd16384);
        fetch_remapped(6'd63, 6'd63);
        fetch_remapped(6'd0, 6'd0);
        // oversize behaves as the store maximum
        program_frame(22'd127, 22'd65, 22'd16384, 22'd0, 22'd16384);
        fetch_remapped(6'd63, 6'd63);
        fetch_remapped(6'd5, 6'd9);
    endtask

    task automatic test_source_clamping();
        // mirrored and steep gains push sources below zero and past the edge
        program_frame(22'd40, 22'd24, 22'h008000, 22'h200000, 22'h007FFF);
        fetch_remapped(6'd0, 6'd0);
        fetch_remapped(6'd39, 6'd23);
        fetch_remapped(6'd63, 6'd63);
        program_frame(22'd40, 22'd24, 22'h007FFF, 22'h1FFFFF, 22'h008000);
        fetch_remapped(6'd0, 6'd23);
        fetch_remapped(6'd63, 6'd0);
    endtask

    task automatic test_random_remap();
        int p;
        gaps_enabled = 1'b1;
        for (p = 0; p < 14; p++) begin
            case (p)
                0:       program_frame(22'd1, 22'd1, random_gain(), random_shear(), random_gain());
                1:       program_frame(22'd64, 22'd64, random_gain(), random_shear(),
                                       random_gain());
                2:       program_frame(22'd64, 22'd64, 22'd16384, 22'd0, 22'd16384);
                default: program_frame(random_size(), random_size(), random_gain(),
                                       random_shear(), random_gain());
            endcase
            run_random_phase(110);
        end
    endtask

    task automatic test_streaming();
        int p;
        gaps_enabled = 1'b0;
        for (p = 0; p < 2; p++) begin
            program_frame(random_size(), random_size(), random_gain(), random_shear(),
                          random_gain());
            run_random_phase(80);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_identity_corners();
        test_frame_size_limits();
        test_source_clamping();
        test_random_remap();
        test_streaming();
        settle_block();
        if (mismatch_count == 0) begin
            $display("perspective_tilt_pixel_remap_core: match");
        end else begin
            $display("perspective_tilt_pixel_remap_core: mismatch");
        end
        $finish;
    end

endmodule
